[sv/spi_flash_uic_controller_macros.svh]
// assertion macros for the spi flash controller checker
// used by spi_flash_uic_controller_checker only
`ifndef SPI_FLASH_UIC_CONTROLLER_MACROS_SVH
`define SPI_FLASH_UIC_CONTROLLER_MACROS_SVH
// implication checked on every clock edge outside reset
`define SFC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("label failed");
// next-cycle implication
`define SFC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("label failed");
`endif

[sv/sfc_pkg.sv]
// package for the spi flash controller: payload types, codes and constants
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package sfc_pkg;
  typedef struct packed {
    logic [1:0]  req_type;
    logic [3:0]  reg_select;
    logic [31:0] write_mask;
    logic [31:0] write_value;
    logic [15:0] preload_index;
  } req_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        irq_request;
  } rsp_t;

  localparam logic [1:0] REQ_READ    = 2'd0;
  localparam logic [1:0] REQ_WRITE   = 2'd1;
  localparam logic [1:0] REQ_PRELOAD = 2'd2;

  localparam logic [3:0] REG_CTRL      = 4'd0;
  localparam logic [3:0] REG_IRQFLAGS  = 4'd1;
  localparam logic [3:0] REG_FIFOSTAT  = 4'd2;
  localparam logic [3:0] REG_DATA      = 4'd3;
  localparam logic [3:0] REG_IRQEN     = 4'd4;
  localparam logic [3:0] REG_READCOUNT = 4'd5;
  localparam logic [3:0] REG_DEVSEL    = 4'd6;
  localparam logic [3:0] REG_GPIOFLASH = 4'd7;
  localparam logic [3:0] REG_GPIOUIC   = 4'd8;

  localparam logic [1:0] CFG_FLASH_BASE  = 2'd0;
  localparam logic [1:0] CFG_FLASH_START = 2'd1;
  localparam logic [1:0] CFG_FLASH_SIZE  = 2'd2;

  localparam logic [7:0] CMD_READ      = 8'h03;
  localparam logic [7:0] CMD_WRDI      = 8'h04;
  localparam logic [7:0] CMD_RDSR      = 8'h05;
  localparam logic [7:0] CMD_WREN      = 8'h06;
  localparam logic [7:0] CMD_FWSTAT7   = 8'h07;
  localparam logic [7:0] CMD_UPDATE    = 8'h09;
  localparam logic [7:0] CMD_INFO      = 8'h0B;
  localparam logic [7:0] CMD_ONE       = 8'h13;
  localparam logic [7:0] CMD_FWSTATE   = 8'h7F;
  localparam logic [7:0] CMD_RDID      = 8'h9F;

  localparam logic [7:0] FW_RESET  = 8'h3F;
  localparam logic [7:0] FW_UPDATE = 8'h79;
  localparam logic [15:0] EE_BASE  = 16'h1101;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MEM,
    ST_OUT,
    ST_CLEAR
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic clear;     // clearing pass step
    logic issue;     // start item, launch memory read
    logic finish;    // update registers, capture result
  } cmd_t;

  typedef struct packed {
    logic clear_done;
  } stat_t;

  // eeprom init image: byte value at address, crc precomputed
  function automatic logic [7:0] ee_init(input logic [10:0] a);
    logic [7:0] v;
    v = 8'h00;
    unique case (a)
      11'h101: v = 8'h87;
      11'h102: v = 8'h0F;
      11'h103: v = 8'h01;
      11'h104: v = 8'h0E;
      11'h105: v = 8'h1E;
      11'h256: v = 8'h01;
      11'h25A: v = 8'h9A;
      11'h25B: v = 8'h1F;
      default: v = 8'h00;
    endcase
    return v;
  endfunction
endpackage
`default_nettype wire

[sv/sfc_ctrl.sv]
// controller state machine: clearing pass then one item at a time
// depends on sfc_pkg
`timescale 1ns / 1ps
`default_nettype none
module sfc_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  wire logic          out_stall,
  input  wire sfc_pkg::stat_t stat,
  output sfc_pkg::cmd_t      cmd
);
  sfc_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= sfc_pkg::ST_CLEAR;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_stall = 1'b1;
    out_valid = 1'b0;
    unique case (state)
      sfc_pkg::ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clear_done) state_next = sfc_pkg::ST_IDLE;
      end
      sfc_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.issue = 1'b1;
          state_next = sfc_pkg::ST_MEM;
        end
      end
      sfc_pkg::ST_MEM: begin
        cmd.finish = 1'b1;
        state_next = sfc_pkg::ST_OUT;
      end
      sfc_pkg::ST_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) state_next = sfc_pkg::ST_IDLE;
      end
      default: state_next = sfc_pkg::ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

[sv/sfc_datapath.sv]
// datapath: register file, flash and eeprom memories, read mux
// depends on sfc_pkg
`timescale 1ns / 1ps
`default_nettype none
module sfc_datapath #(
  parameter int FLASH_DEPTH = 65536
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire sfc_pkg::cmd_t cmd,
  output sfc_pkg::stat_t     stat,
  input  wire sfc_pkg::req_t in_data,
  output sfc_pkg::rsp_t      out_data,
  input  wire logic          cfg_write,
  input  wire logic [1:0]    cfg_index,
  input  wire logic [31:0]   cfg_data
);
  localparam int FAW = $clog2(FLASH_DEPTH);
  localparam int EE_DEPTH = 2048;

  logic [31:0] flash_base;
  logic [15:0] flash_start;
  logic [16:0] flash_size;

  always_ff @(posedge clk) begin
    if (rst) begin
      flash_base <= '0; flash_start <= '0; flash_size <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        sfc_pkg::CFG_FLASH_BASE:  flash_base <= cfg_data;
        sfc_pkg::CFG_FLASH_START: flash_start <= cfg_data[15:0];
        sfc_pkg::CFG_FLASH_SIZE:  flash_size <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  logic [31:0] control_reg, irq_flags, irq_enable, read_remaining, device_select;
  logic [31:0] spi_address;
  logic [2:0]  write_counter;
  logic [7:0]  current_command, flash_status_reg, uic_fw_state;
  sfc_pkg::req_t req;

  // clearing pass counter over eeprom
  logic [11:0] clr_cnt;
  assign stat.clear_done = clr_cnt[11];

  logic [7:0] eeprom [EE_DEPTH];
  logic [7:0] flash  [FLASH_DEPTH];
  logic [7:0] ee_q, fl_q;

  // addresses for the read launched at issue, from the state before the item
  logic [31:0] ee_next_addr, fl_off;
  logic [10:0] ee_ra;
  logic [FAW-1:0] fl_ra;
  logic [32:0] fl_sum;
  assign ee_next_addr = spi_address + 32'h0001_0000;
  assign ee_ra = 11'(ee_next_addr[31:16] - sfc_pkg::EE_BASE);
  assign fl_off = spi_address - flash_base;
  assign fl_sum = {17'd0, flash_start} + {1'b0, fl_off};
  assign fl_ra = fl_sum[FAW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      eeprom[clr_cnt[10:0]] <= sfc_pkg::ee_init(clr_cnt[10:0]);
    end
    ee_q <= eeprom[ee_ra];
  end

  always_ff @(posedge clk) begin
    if (cmd.issue && in_data.req_type == sfc_pkg::REQ_PRELOAD)
      flash[FAW'(in_data.preload_index)] <= in_data.write_value[7:0];
    fl_q <= flash[fl_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) clr_cnt <= '0;
    else if (cmd.clear && !clr_cnt[11]) clr_cnt <= clr_cnt + 12'd1;
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) req <= in_data;
  end

  // finish-cycle computation
  logic [31:0] c_ctrl, c_flags, c_en, c_rem, c_dev, c_addr, rd, m, d;
  logic [2:0]  c_wc;
  logic [7:0]  c_cmd, c_fst, c_fw;
  logic        irq, in_win;
  logic [16:0] win;

  always_comb begin
    c_ctrl = control_reg; c_flags = irq_flags; c_en = irq_enable;
    c_rem = read_remaining; c_dev = device_select; c_addr = spi_address;
    c_wc = write_counter; c_cmd = current_command; c_fst = flash_status_reg;
    c_fw = uic_fw_state; rd = '0; irq = 1'b0;
    m = req.write_mask; d = req.write_value & req.write_mask;
    win = flash_size - {1'b0, flash_start};
    in_win = (flash_size > {1'b0, flash_start}) && (spi_address >= flash_base)
             && (fl_off < {15'd0, win});
    if (req.req_type == sfc_pkg::REQ_READ) begin
      unique case (req.reg_select)
        sfc_pkg::REG_CTRL:     rd = control_reg;
        sfc_pkg::REG_IRQFLAGS: rd = irq_flags;
        sfc_pkg::REG_FIFOSTAT:
          rd = {19'd0, (read_remaining < 32'h10) ? read_remaining[4:0] : 5'h10, 8'h10};
        sfc_pkg::REG_DATA: begin
          if (read_remaining != 0 && control_reg[1]) begin
            c_rem = read_remaining - 32'd1;
            if (irq_enable[6] && c_rem <= 32'h10) begin
              c_flags[6] = 1'b1; irq = 1'b1;
            end
            if (device_select == 32'd1) begin
              priority case (current_command)
                sfc_pkg::CMD_READ: begin
                  c_addr = spi_address + 32'd1;
                  rd = in_win ? {24'd0, fl_q} : '0;
                end
                sfc_pkg::CMD_RDSR: rd = {24'd0, flash_status_reg};
                sfc_pkg::CMD_RDID: begin
                  c_addr = spi_address + 32'd1;
                  rd = (spi_address == 32'd0) ? 32'h20 :
                       (spi_address == 32'd1) ? 32'hBA :
                       (spi_address == 32'd2) ? 32'h19 : 32'd0;
                end
                default: rd = '0;
              endcase
            end else if (device_select == 32'd2) begin
              priority case (current_command)
                sfc_pkg::CMD_READ: begin
                  c_addr = ee_next_addr; rd = {24'd0, ee_q};
                end
                sfc_pkg::CMD_RDSR: rd = '0;
                sfc_pkg::CMD_FWSTAT7: begin
                  c_addr = spi_address + 32'd1;
                  rd = (spi_address == 32'h7F) ? 32'hFF : 32'd0;
                end
                sfc_pkg::CMD_INFO: begin
                  c_addr = spi_address + 32'd1;
                  rd = (spi_address == 32'd0) ? 32'h28 :
                       (spi_address == 32'd3) ? 32'h58 : 32'd0;
                end
                sfc_pkg::CMD_ONE:     rd = 32'h01;
                sfc_pkg::CMD_FWSTATE: rd = {24'd0, uic_fw_state};
                default:              rd = {24'd0, sfc_pkg::FW_UPDATE};
              endcase
            end
          end
        end
        sfc_pkg::REG_IRQEN:     rd = irq_enable;
        sfc_pkg::REG_READCOUNT: rd = read_remaining;
        sfc_pkg::REG_DEVSEL:    rd = device_select;
        default:                rd = '0;
      endcase
    end else if (req.req_type == sfc_pkg::REQ_WRITE) begin
      unique case (req.reg_select)
        sfc_pkg::REG_CTRL: begin
          c_ctrl = (control_reg & ~m) | d;
          if (c_ctrl[9]) c_wc = '0;
        end
        sfc_pkg::REG_IRQFLAGS: c_flags = irq_flags & ~d;
        sfc_pkg::REG_DATA: begin
          if (!control_reg[1]) begin
            if (write_counter != 3'd7) c_wc = write_counter + 3'd1;
            if (c_wc == 3'd1) begin
              c_cmd = d[7:0]; c_addr = '0;
            end else if (c_wc < 3'd6) begin
              c_addr = spi_address | (d << {3'd5 - c_wc, 3'd0});
            end
            if (irq_enable[7]) begin
              c_flags[7] = 1'b1; irq = 1'b1;
            end
            if (device_select == 32'd1) begin
              if (c_cmd == sfc_pkg::CMD_WRDI) c_fst[1] = 1'b0;
              else if (c_cmd == sfc_pkg::CMD_WREN) c_fst[1] = 1'b1;
            end else if (device_select == 32'd2) begin
              if (c_cmd == sfc_pkg::CMD_UPDATE) c_fw = sfc_pkg::FW_UPDATE;
            end
          end
        end
        sfc_pkg::REG_IRQEN: c_en = (irq_enable & ~m) | d;
        sfc_pkg::REG_READCOUNT: begin
          c_rem = (read_remaining & ~m) | d;
          if (irq_enable[6] && c_rem <= 32'h10) begin
            c_flags[6] = 1'b1; irq = 1'b1;
          end
        end
        sfc_pkg::REG_DEVSEL: c_dev = (device_select & ~m) | d;
        sfc_pkg::REG_GPIOFLASH: if (d[9]) c_dev[0] = ~req.write_value[8];
        sfc_pkg::REG_GPIOUIC:   if (d[9]) c_dev[1] = ~req.write_value[8];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      control_reg <= '0; irq_flags <= '0; irq_enable <= '0; read_remaining <= '0;
      device_select <= '0; spi_address <= '0; write_counter <= '0;
      current_command <= '0; flash_status_reg <= '0; uic_fw_state <= sfc_pkg::FW_RESET;
    end else if (cmd.finish) begin
      control_reg <= c_ctrl; irq_flags <= c_flags; irq_enable <= c_en;
      read_remaining <= c_rem; device_select <= c_dev; spi_address <= c_addr;
      write_counter <= c_wc; current_command <= c_cmd; flash_status_reg <= c_fst;
      uic_fw_state <= c_fw;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_data.read_data <= rd;
      out_data.irq_request <= irq;
    end
  end
endmodule
`default_nettype wire

[sv/spi_flash_uic_controller.sv]
// spi flash controller: emulated register interface with flash and eeprom
// request channel (req_valid/req_stall) carries one register access per transaction;
// response channel (rsp_valid/rsp_stall) returns one result per transaction
// sequence: accept and launch the memory read, then update the registers and capture
// the result, then hold the result in the output register until taken; the update
// waits for the registered flash/eeprom read port
// only one transaction is in flight; req_stall stays high until rsp is taken
// after rst the eeprom runs a clearing pass over its 2048 entries, writing its
// init image, with req_stall high
// configuration writes are taken throughout
// a stalled response holds its payload unchanged
// cfg_write/cfg_index/cfg_data write flash_base, flash_start, flash_size
// the flash store holds whatever was preloaded; unwritten bytes are undefined
// depends on sfc_pkg, sfc_ctrl, sfc_datapath
`timescale 1ns / 1ps
`default_nettype none
module spi_flash_uic_controller #(
  parameter int FLASH_DEPTH = 65536
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_stall,
  input  wire sfc_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_stall,
  output sfc_pkg::rsp_t      rsp,
  input  wire logic          cfg_write,
  input  wire logic [1:0]    cfg_index,
  input  wire logic [31:0]   cfg_data
);
  sfc_pkg::cmd_t  cmd;
  sfc_pkg::stat_t stat;

  sfc_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(req_valid), .in_stall(req_stall),
    .out_valid(rsp_valid), .out_stall(rsp_stall), .stat(stat), .cmd(cmd)
  );

  sfc_datapath #(.FLASH_DEPTH(FLASH_DEPTH)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat), .in_data(req), .out_data(rsp),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );
endmodule
`default_nettype wire

[sv/spi_flash_uic_controller_checker.sv]
// port-level checker for the spi flash controller, bound to the top level
// depends on sfc_pkg and spi_flash_uic_controller_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "spi_flash_uic_controller_macros.svh"
module spi_flash_uic_controller_checker (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          req_valid,
  input wire logic          req_stall,
  input wire logic          rsp_valid,
  input wire logic          rsp_stall,
  input wire sfc_pkg::rsp_t rsp
);
  // one transaction in flight: no request taken while a response waits
  `SFC_ASSERT_IMPL(a_no_accept_busy, rsp_valid, req_stall)
  // an accepted request gives no response in the very next cycle
  `SFC_ASSERT_NEXT(a_no_early_rsp, req_valid && !req_stall, !rsp_valid)
  // a response taken is followed by readiness, not a second response
  `SFC_ASSERT_NEXT(a_single_rsp, rsp_valid && !rsp_stall, !rsp_valid)
  // stalled response keeps its payload
  `SFC_ASSERT_NEXT(a_hold, rsp_valid && rsp_stall, $stable(rsp))
endmodule

bind spi_flash_uic_controller spi_flash_uic_controller_checker u_checker (
  .clk(clk), .rst(rst), .req_valid(req_valid), .req_stall(req_stall),
  .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
);
`default_nettype wire

[sim/spi_flash_uic_controller_checker.sv]
// checker for the spi flash controller: watches both channels and the config port,
// predicts each response and compares it field by field; depends on sfc_pkg
`timescale 1ns / 1ps
module spi_flash_uic_controller_scoreboard (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  input  logic          req_stall,
  input  sfc_pkg::req_t req,
  input  logic          rsp_valid,
  input  logic          rsp_stall,
  input  sfc_pkg::rsp_t rsp,
  input  logic          cfg_write,
  input  logic [1:0]    cfg_index,
  input  logic [31:0]   cfg_data,
  output int            errors,
  output int            pending
);
  localparam int FLASH_WORDS = 65536;

  logic [31:0] map_base, map_start, map_size;
  logic [31:0] ctrl_r, flags_r, enable_r, remain_r, devsel_r, addr_r;
  logic [2:0]  wcount_r;
  logic [7:0]  cmd_r, fstat_r, fw_r;
  logic [7:0]  eeprom_img [0:2047];
  logic [7:0]  flash_img [0:FLASH_WORDS-1];
  sfc_pkg::rsp_t want_q [$];

  task automatic seal_crc(input int pos, input int len);
    logic [15:0] crc;
    crc = 16'hFFFF;
    for (int i = 0; i < len; i++) begin
      crc ^= {8'h00, eeprom_img[(pos + i) & 'h7FF]};
      for (int b = 0; b < 8; b++)
        crc = crc[0] ? ((crc >> 1) ^ 16'h8408) : (crc >> 1);
    end
    eeprom_img[(pos + len) & 'h7FF] = crc[7:0];
    eeprom_img[(pos + len + 1) & 'h7FF] = crc[15:8];
  endtask

  initial begin
    errors = 0;
    pending = 0;
    for (int i = 0; i < 2048; i++) eeprom_img[i] = 8'h00;
    for (int i = 0; i < FLASH_WORDS; i++) flash_img[i] = 8'h00;
    // board, region and language entries
    eeprom_img['h100] = 8'h00;
    seal_crc('h100, 1);
    eeprom_img['h103] = 8'h01;
    seal_crc('h103, 1);
    eeprom_img['h256] = 8'h01;
    seal_crc('h256, 4);
  end

  function automatic logic [31:0] blend(logic [31:0] old, logic [31:0] m, logic [31:0] v);
    return (old & ~m) | (v & m);
  endfunction

  task automatic data_fetch(output logic [31:0] rd, inout logic irq);
    logic [31:0] a;
    rd = 0;
    if (remain_r == 0 || !ctrl_r[1]) return;
    remain_r = remain_r - 1;
    if (enable_r[6] && remain_r <= 32'h10) begin
      flags_r[6] = 1'b1;
      irq = 1'b1;
    end
    if (devsel_r == 1) begin
      case (cmd_r)
        sfc_pkg::CMD_READ: begin
          a = addr_r;
          addr_r = addr_r + 1;
          if (map_size > map_start && a >= map_base && (a - map_base) < (map_size - map_start))
            rd = flash_img[(map_start + (a - map_base)) % FLASH_WORDS];
        end
        sfc_pkg::CMD_RDSR: rd = fstat_r;
        sfc_pkg::CMD_RDID: begin
          a = addr_r;
          addr_r = addr_r + 1;
          if (a == 0) rd = 32'h20;
          else if (a == 1) rd = 32'hBA;
          else if (a == 2) rd = 32'h19;
        end
        default: rd = 0;
      endcase
    end else if (devsel_r == 2) begin
      case (cmd_r)
        sfc_pkg::CMD_READ: begin
          addr_r = addr_r + 32'h10000;
          rd = eeprom_img[((addr_r >> 16) - 32'h1101) & 32'h7FF];
        end
        sfc_pkg::CMD_RDSR: rd = 0;
        sfc_pkg::CMD_FWSTAT7: begin
          a = addr_r;
          addr_r = addr_r + 1;
          rd = (a == 32'h7F) ? 32'hFF : 0;
        end
        sfc_pkg::CMD_INFO: begin
          a = addr_r;
          addr_r = addr_r + 1;
          if (a == 0) rd = 32'h28;
          else if (a == 3) rd = 32'h58;
        end
        sfc_pkg::CMD_ONE: rd = 32'h01;
        sfc_pkg::CMD_FWSTATE: rd = fw_r;
        default: rd = {24'h0, sfc_pkg::FW_UPDATE};
      endcase
    end
  endtask

  task automatic data_push(input logic [31:0] m, input logic [31:0] v, inout logic irq);
    logic [31:0] d;
    d = v & m;
    if (ctrl_r[1]) return;
    if (wcount_r < 7) wcount_r = wcount_r + 1;
    if (wcount_r == 1) begin
      cmd_r = d[7:0];
      addr_r = 0;
    end else if (wcount_r < 6) begin
      addr_r |= d << ((5 - wcount_r) * 8);
    end
    if (enable_r[7]) begin
      flags_r[7] = 1'b1;
      irq = 1'b1;
    end
    if (devsel_r == 1) begin
      if (cmd_r == sfc_pkg::CMD_WRDI) fstat_r[1] = 1'b0;
      else if (cmd_r == sfc_pkg::CMD_WREN) fstat_r[1] = 1'b1;
    end else if (devsel_r == 2) begin
      if (cmd_r == sfc_pkg::CMD_UPDATE) fw_r = sfc_pkg::FW_UPDATE;
    end
  endtask

  task automatic predict_access(input sfc_pkg::req_t r, output sfc_pkg::rsp_t o);
    logic [31:0] rd;
    logic        irq;
    rd = 0;
    irq = 0;
    if (r.req_type == sfc_pkg::REQ_READ) begin
      case (r.reg_select)
        sfc_pkg::REG_CTRL:      rd = ctrl_r;
        sfc_pkg::REG_IRQFLAGS:  rd = flags_r;
        sfc_pkg::REG_FIFOSTAT:
          rd = ((remain_r < 32'h10 ? remain_r : 32'h10) << 8) | 32'h10;
        sfc_pkg::REG_DATA:      data_fetch(rd, irq);
        sfc_pkg::REG_IRQEN:     rd = enable_r;
        sfc_pkg::REG_READCOUNT: rd = remain_r;
        sfc_pkg::REG_DEVSEL:    rd = devsel_r;
        default:                rd = 0;
      endcase
    end else if (r.req_type == sfc_pkg::REQ_WRITE) begin
      case (r.reg_select)
        sfc_pkg::REG_CTRL: begin
          ctrl_r = blend(ctrl_r, r.write_mask, r.write_value);
          if (ctrl_r[9]) wcount_r = 0;
        end
        sfc_pkg::REG_IRQFLAGS: flags_r &= ~(r.write_value & r.write_mask);
        sfc_pkg::REG_DATA:     data_push(r.write_mask, r.write_value, irq);
        sfc_pkg::REG_IRQEN:    enable_r = blend(enable_r, r.write_mask, r.write_value);
        sfc_pkg::REG_READCOUNT: begin
          remain_r = blend(remain_r, r.write_mask, r.write_value);
          if (enable_r[6] && remain_r <= 32'h10) begin
            flags_r[6] = 1'b1;
            irq = 1'b1;
          end
        end
        sfc_pkg::REG_DEVSEL: devsel_r = blend(devsel_r, r.write_mask, r.write_value);
        sfc_pkg::REG_GPIOFLASH:
          if (r.write_value[9] & r.write_mask[9]) devsel_r[0] = ~r.write_value[8];
        sfc_pkg::REG_GPIOUIC:
          if (r.write_value[9] & r.write_mask[9]) devsel_r[1] = ~r.write_value[8];
        default: ;
      endcase
    end else if (r.req_type == sfc_pkg::REQ_PRELOAD) begin
      flash_img[r.preload_index % FLASH_WORDS] = r.write_value[7:0];
    end
    o.read_data = rd;
    o.irq_request = irq;
  endtask

  always @(posedge clk) begin
    sfc_pkg::rsp_t want, got;
    if (rst) begin
      map_base = 0;
      map_start = 0;
      map_size = 0;
      ctrl_r = 0;
      flags_r = 0;
      enable_r = 0;
      remain_r = 0;
      devsel_r = 0;
      addr_r = 0;
      wcount_r = 0;
      cmd_r = 0;
      fstat_r = 0;
      fw_r = sfc_pkg::FW_RESET;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          sfc_pkg::CFG_FLASH_BASE:  map_base = cfg_data;
          sfc_pkg::CFG_FLASH_START: map_start = {16'h0, cfg_data[15:0]};
          sfc_pkg::CFG_FLASH_SIZE:  map_size = {15'h0, cfg_data[16:0]};
          default: ;
        endcase
      end
      if (rsp_valid && !rsp_stall) begin
        got = rsp;
        if (want_q.size() == 0) begin
          $error("response transaction with nothing expected: %h", got);
          errors++;
        end else begin
          want = want_q.pop_front();
          if (got.read_data !== want.read_data) begin
            $error("read_data expected %h actual %h", want.read_data, got.read_data);
            errors++;
          end
          if (got.irq_request !== want.irq_request) begin
            $error("irq_request expected %b actual %b", want.irq_request, got.irq_request);
            errors++;
          end
        end
      end
      if (req_valid && !req_stall) begin
        predict_access(req, want);
        want_q.push_back(want);
      end
    end
    pending = want_q.size();
  end
endmodule

[sim/spi_flash_uic_controller_tb.sv]
// testbench top for the spi flash controller: clock, reset, stimulus and verdict
// depends on sfc_pkg, spi_flash_uic_controller and spi_flash_uic_controller_scoreboard
`timescale 1ns / 1ps
module spi_flash_uic_controller_tb;
  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          req_valid = 1'b0;
  logic          req_stall;
  sfc_pkg::req_t req = '0;
  logic          rsp_valid;
  logic          rsp_stall = 1'b0;
  sfc_pkg::rsp_t rsp;
  logic          cfg_write = 1'b0;
  logic [1:0]    cfg_index = sfc_pkg::CFG_FLASH_BASE;
  logic [31:0]   cfg_data = '0;
  int            errors, pending;
  int            gap_pct = 0, stall_pct = 0, hold_cycles = 0;
  int            sent = 0;
  logic [31:0]   cur_base = 0;

  always #2 clk = ~clk;

  spi_flash_uic_controller DUT (
    .clk, .rst, .req_valid, .req_stall, .req, .rsp_valid, .rsp_stall, .rsp,
    .cfg_write, .cfg_index, .cfg_data
  );

  spi_flash_uic_controller_scoreboard u_checker (
    .clk, .rst, .req_valid, .req_stall, .req, .rsp_valid, .rsp_stall, .rsp,
    .cfg_write, .cfg_index, .cfg_data, .errors, .pending
  );

  // receiver: random stalls, or a long hold-off when asked
  initial begin
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        rsp_stall <= 1'b1;
        hold_cycles--;
      end else begin
        rsp_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  initial begin
    #2000000;
    $display("spi_flash_uic_controller_tb: FAIL");
    $finish;
  end

  task automatic issue(input logic [1:0] kind, input logic [3:0] sel,
                       input logic [31:0] m, input logic [31:0] v, input logic [15:0] idx);
    sfc_pkg::req_t r;
    r.req_type = kind;
    r.reg_select = sel;
    r.write_mask = m;
    r.write_value = v;
    r.preload_index = idx;
    while ($urandom_range(99) < gap_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    sent++;
  endtask

  task automatic wr(input logic [3:0] sel, input logic [31:0] v);
    issue(sfc_pkg::REQ_WRITE, sel, 32'hFFFF_FFFF, v, 16'($urandom));
  endtask

  task automatic rd(input logic [3:0] sel);
    issue(sfc_pkg::REQ_READ, sel, $urandom, $urandom, 16'($urandom));
  endtask

  // setup only once the block is drained
  task automatic set_window(input logic [31:0] base, input logic [31:0] start,
                            input logic [31:0] size);
    logic [31:0] vals [3];
    vals = '{base, start, size};
    req_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    for (int i = 0; i < 3; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= 2'(i);
      cfg_data <= vals[i];
      @(posedge clk);
    end
    cfg_write <= 1'b0;
    cur_base = base;
  endtask

  // full command: reset byte counter, select device, command, address, then reads
  task automatic command_burst();
    logic [7:0]  cmd;
    logic [31:0] addr, dev;
    int          extra, n;
    logic [7:0]  cmd_set [11];
    cmd_set = '{sfc_pkg::CMD_READ, sfc_pkg::CMD_READ, sfc_pkg::CMD_READ, sfc_pkg::CMD_WRDI,
                sfc_pkg::CMD_RDSR, sfc_pkg::CMD_WREN, sfc_pkg::CMD_FWSTAT7,
                sfc_pkg::CMD_UPDATE, sfc_pkg::CMD_INFO, sfc_pkg::CMD_ONE,
                sfc_pkg::CMD_FWSTATE};
    dev = ($urandom_range(9) == 0) ? $urandom : 32'($urandom_range(1, 2));
    cmd = ($urandom_range(7) == 0) ? 8'($urandom) :
          ($urandom_range(5) == 0) ? sfc_pkg::CMD_RDID : cmd_set[$urandom_range(10)];
    if (cmd == sfc_pkg::CMD_READ && dev == 1) addr = cur_base + $urandom_range(300) - 8;
    else if (cmd == sfc_pkg::CMD_READ)
      addr = {16'h10F8 + 16'($urandom_range(2100)), 16'($urandom)};
    else if (cmd == sfc_pkg::CMD_FWSTAT7) addr = 32'h7C + $urandom_range(5);
    else if (cmd == sfc_pkg::CMD_RDID || cmd == sfc_pkg::CMD_INFO) addr = 0;
    else addr = $urandom;
    wr(sfc_pkg::REG_CTRL, 32'h200 | ($urandom & 32'hFFFF_FDFD));
    wr(sfc_pkg::REG_CTRL, $urandom & 32'hFFFF_FDFD);
    if ($urandom_range(3) == 0) wr(sfc_pkg::REG_IRQEN, $urandom);
    wr(sfc_pkg::REG_DEVSEL, dev);
    wr(sfc_pkg::REG_DATA, {($urandom_range(7) == 0) ? 24'($urandom) : 24'h0, cmd});
    for (int i = 3; i >= 0; i--) begin
      if ($urandom_range(9) == 0)
        issue(sfc_pkg::REQ_WRITE, sfc_pkg::REG_DATA, $urandom, addr[i*8 +: 8], 0);
      else wr(sfc_pkg::REG_DATA, {24'h0, addr[i*8 +: 8]});
    end
    extra = ($urandom_range(5) == 0) ? $urandom_range(1, 4) : 0;
    for (int i = 0; i < extra; i++) wr(sfc_pkg::REG_DATA, $urandom);
    wr(sfc_pkg::REG_CTRL, 32'h2 | ($urandom & 32'hFFFF_FDFC));
    wr(sfc_pkg::REG_READCOUNT,
       ($urandom_range(9) == 0) ? $urandom : 32'($urandom_range(30)));
    n = $urandom_range(1, 20);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(7) == 0) rd(4'($urandom_range(8)));
      else rd(sfc_pkg::REG_DATA);
    end
  endtask

  task automatic noise_item();
    logic [31:0] m;
    m = ($urandom_range(1) == 0) ? 32'hFFFF_FFFF : $urandom;
    issue(2'($urandom), 4'($urandom), m, $urandom, 16'($urandom));
  endtask

  initial begin
    logic [31:0] win_base [5];
    logic [31:0] win_start [5];
    logic [31:0] win_size [5];
    win_base = '{32'h0, 32'hFFFF_FF00, 32'hFFFF_FFFF, 32'h1234, 32'h0000_0100};
    win_start = '{32'h0, 32'hFF00, 32'hFFFF_FFFF, 32'h80, 32'h10};
    win_size = '{32'h100, 32'h10000, 32'hFFFF_FFFF, 32'h40, 32'hF0};
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // fill both ends of the store so every mapped window is defined
    for (int i = 0; i < 256; i++) begin
      issue(sfc_pkg::REQ_PRELOAD, 4'($urandom), $urandom, $urandom, 16'(i));
      issue(sfc_pkg::REQ_PRELOAD, 4'($urandom), $urandom, $urandom, 16'(16'hFF00 + i));
    end

    // directed: every register read, ignored kinds, zero-count read of the id command
    for (int s = 0; s < 16; s++) rd(4'(s));
    issue(2'd3, sfc_pkg::REG_CTRL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
    wr(sfc_pkg::REG_FIFOSTAT, 32'hFFFF_FFFF);
    wr(sfc_pkg::REG_GPIOFLASH, 32'h0000_0200);
    wr(sfc_pkg::REG_GPIOUIC, 32'h0000_0300);
    wr(sfc_pkg::REG_DATA, {24'h0, sfc_pkg::CMD_RDID});
    wr(sfc_pkg::REG_CTRL, 32'h2);
    rd(sfc_pkg::REG_DATA);

    for (int ph = 0; ph < 6; ph++) begin
      set_window(win_base[ph % 5], win_start[ph % 5], win_size[ph % 5]);
      case (ph / 2)
        0: begin gap_pct = 20; stall_pct = 77; end
        1: begin gap_pct = 77; stall_pct = 20; end
        default: begin gap_pct = 0; stall_pct = 0; end
      endcase
      if (ph == 4) hold_cycles = 400;
      while (sent < 560 + (ph + 1) * 225) begin
        if ($urandom_range(9) < 7) command_burst();
        else noise_item();
      end
    end
    req_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) $display("spi_flash_uic_controller_tb: PASS");
    else $display("spi_flash_uic_controller_tb: FAIL");
    $finish;
  end
endmodule

[sim.f]
+incdir+sv
sv/sfc_pkg.sv
sv/sfc_ctrl.sv
sv/sfc_datapath.sv
sv/spi_flash_uic_controller.sv
sv/spi_flash_uic_controller_checker.sv
sim/spi_flash_uic_controller_checker.sv
sim/spi_flash_uic_controller_tb.sv
